### hw/rtl/timed_fault_slot_table_unit_assert.svh
// Assertion macros shared by the fault slot table RTL.
// Included by the sequencer and the datapath; needs nothing else.
`ifndef TIMED_FAULT_SLOT_TABLE_UNIT_ASSERT_SVH
`define TIMED_FAULT_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TFST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tfst_pkg.sv
// Shared types, codes and microcode ROM for the timed fault slot table.
// No dependencies; imported by every module of the block.
`default_nettype none

package tfst_pkg;

  localparam int NUM_SLOTS_DEFAULT = 8;
  localparam logic [15:0] SAG_DEFAULT_MV = 16'd10000;

  // operations
  localparam logic [1:0] OP_INJECT    = 2'd0;
  localparam logic [1:0] OP_CLEAR_ONE = 2'd1;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  // fault kinds
  localparam logic [2:0] KIND_GPS     = 3'd1;
  localparam logic [2:0] KIND_FREEZE  = 3'd2;
  localparam logic [2:0] KIND_SAG     = 3'd3;
  localparam logic [2:0] KIND_COMMS   = 3'd4;
  localparam logic [2:0] KIND_CORRUPT = 3'd5;

  // datapath actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_INJ_WR   = 3'd1;
  localparam logic [2:0] ACT_CLR_ONE  = 3'd2;
  localparam logic [2:0] ACT_CLR_ALL  = 3'd3;
  localparam logic [2:0] ACT_FLAG_ACC = 3'd4;
  localparam logic [2:0] ACT_TICK_ACC = 3'd5;
  localparam logic [2:0] ACT_TICK_END = 3'd6;
  localparam logic [2:0] ACT_EMIT     = 3'd7;

  // slot counter operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_ZERO = 2'd1;
  localparam logic [1:0] CNT_STEP = 2'd2;  // increment unless the branch is taken

  // branch conditions
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_START  = 2'd1;  // dispatch on op
  localparam logic [1:0] COND_HIT    = 2'd2;  // free slot found or table end
  localparam logic [1:0] COND_LAST   = 2'd3;  // counter on the last slot

  // microprogram steps
  localparam logic [3:0] STEP_IDLE   = 4'd0;
  localparam logic [3:0] STEP_SRCH   = 4'd1;
  localparam logic [3:0] STEP_WRITE  = 4'd2;
  localparam logic [3:0] STEP_REWIND = 4'd3;
  localparam logic [3:0] STEP_FLAGS  = 4'd4;
  localparam logic [3:0] STEP_TICK   = 4'd5;
  localparam logic [3:0] STEP_TEND   = 4'd6;
  localparam logic [3:0] STEP_EMIT   = 4'd7;
  localparam logic [3:0] STEP_CLR1   = 4'd8;
  localparam logic [3:0] STEP_CLRA   = 4'd9;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  fault_kind;
    logic [15:0] sag_level_in;
    logic [31:0] duration_in;
    logic [31:0] now_ms;
    logic [2:0]  slot_sel;
  } in_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic        inject_ok;
    logic        gps_fault;
    logic        imu_stuck;
    logic        battery_sag;
    logic [15:0] sag_level_out;
    logic        link_down;
    logic        packet_corrupt;
    logic [3:0]  fault_flags;
  } out_t;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] cnt_op;
    logic [1:0] cond;
    logic [3:0] jmp;
    logic [3:0] nxt;
  } ucw_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] act;
  } ctrl_t;

  function automatic ucw_t ucode_word(input logic [3:0] pc);
    ucw_t w;
    unique case (pc)
      STEP_IDLE:   w = '{ACT_NONE,     CNT_ZERO, COND_START,  STEP_IDLE,   STEP_IDLE};
      STEP_SRCH:   w = '{ACT_NONE,     CNT_STEP, COND_HIT,    STEP_WRITE,  STEP_SRCH};
      STEP_WRITE:  w = '{ACT_INJ_WR,   CNT_HOLD, COND_ALWAYS, STEP_REWIND, STEP_REWIND};
      STEP_REWIND: w = '{ACT_NONE,     CNT_ZERO, COND_ALWAYS, STEP_FLAGS,  STEP_FLAGS};
      STEP_FLAGS:  w = '{ACT_FLAG_ACC, CNT_STEP, COND_LAST,   STEP_EMIT,   STEP_FLAGS};
      STEP_TICK:   w = '{ACT_TICK_ACC, CNT_STEP, COND_LAST,   STEP_TEND,   STEP_TICK};
      STEP_TEND:   w = '{ACT_TICK_END, CNT_HOLD, COND_ALWAYS, STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:   w = '{ACT_EMIT,     CNT_ZERO, COND_ALWAYS, STEP_IDLE,   STEP_IDLE};
      STEP_CLR1:   w = '{ACT_CLR_ONE,  CNT_ZERO, COND_ALWAYS, STEP_FLAGS,  STEP_FLAGS};
      STEP_CLRA:   w = '{ACT_CLR_ALL,  CNT_ZERO, COND_ALWAYS, STEP_EMIT,   STEP_EMIT};
      default:     w = '{ACT_NONE,     CNT_ZERO, COND_ALWAYS, STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] op_entry(input logic [1:0] op);
    logic [3:0] s;
    unique case (op)
      OP_INJECT:    s = STEP_SRCH;
      OP_CLEAR_ONE: s = STEP_CLR1;
      OP_CLEAR_ALL: s = STEP_CLRA;
      OP_TICK:      s = STEP_TICK;
      default:      s = STEP_IDLE;
    endcase
    return s;
  endfunction

  // derived-output bit of a fault kind; unused kinds drive nothing
  function automatic logic [4:0] kind_bit(input logic [2:0] kind);
    logic [4:0] b;
    unique case (kind)
      KIND_GPS:     b = 5'b00001;
      KIND_FREEZE:  b = 5'b00010;
      KIND_SAG:     b = 5'b00100;
      KIND_COMMS:   b = 5'b01000;
      KIND_CORRUPT: b = 5'b10000;
      default:      b = 5'b00000;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tfst_sequencer.sv
// Microcode sequencer: step counter, ROM lookup, branch logic and slot counter.
// Depends on tfst_pkg and the assertion macro header.
`default_nettype none
`include "timed_fault_slot_table_unit_assert.svh"

module tfst_sequencer
  import tfst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
  parameter int CW = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    op,
  input  wire logic          slot_hit,
  output      ctrl_t         ctrl,
  output      logic [CW-1:0] cnt,
  output      logic [CW-1:0] cnt_next,
  output      logic          busy
);

  logic [3:0] pc;
  logic [3:0] pc_next;
  ucw_t       uw;
  logic       taken;
  logic       accept;
  logic       last;

  assign uw     = ucode_word(pc);
  assign busy   = (pc != STEP_IDLE);
  assign accept = start && !busy;
  assign last   = (cnt == CW'(NUM_SLOTS - 1));

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: taken = 1'b1;
      COND_START:  taken = accept;
      COND_HIT:    taken = slot_hit;
      COND_LAST:   taken = last;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_next = (uw.cond == COND_START) ? op_entry(op) : uw.jmp;
    end else begin
      pc_next = uw.nxt;
    end
  end

  always_comb begin
    unique case (uw.cnt_op)
      CNT_HOLD: cnt_next = cnt;
      CNT_ZERO: cnt_next = '0;
      CNT_STEP: cnt_next = taken ? cnt : cnt + CW'(1);
      default:  cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_IDLE;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

  assign ctrl = '{accept: accept, act: uw.act};

  `TFST_ASSERT_NEXT(a_dispatch, clk, rst, accept, (pc == STEP_SRCH) || (pc == STEP_CLR1) || (pc == STEP_CLRA) || (pc == STEP_TICK), "accepted word did not reach an entry step")
  `TFST_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, cnt <= CW'(NUM_SLOTS), "slot counter past table end")
  `TFST_ASSERT_NOW(a_walk_range, clk, rst, (pc == STEP_FLAGS) || (pc == STEP_TICK), cnt < CW'(NUM_SLOTS), "walk outside the slot table")

endmodule

`default_nettype wire

### hw/rtl/tfst_datapath.sv
// Slot storage, active bits, derived outputs and result register.
// Depends on tfst_pkg and the assertion macro header.
`default_nettype none
`include "timed_fault_slot_table_unit_assert.svh"

module tfst_datapath
  import tfst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
  parameter int CW = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire in_t           cmd,
  input  wire ctrl_t         ctrl,
  input  wire logic [CW-1:0] cnt,
  input  wire logic [CW-1:0] cnt_next,
  output      logic          slot_hit,
  output      logic          done,
  output      out_t          result
);

  localparam int AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NPAD = 1 << AW;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start;
    logic [31:0] duration;
    logic [15:0] sag;
  } slot_t;

  slot_t           slot_mem [NPAD];
  slot_t           slot_rd;
  logic [NPAD-1:0] active;
  logic [4:0]      derived_bits;
  logic [15:0]     derived_sag;

  in_t         req;
  logic [2:0]  idx;
  logic        ok;
  logic [3:0]  flags;
  logic [4:0]  bits_acc;
  logic [15:0] sag_acc;

  logic [AW-1:0] waddr;
  logic [AW-1:0] sel_idx;
  logic          at_end;
  logic          sel_ok;
  logic          cur_active;
  logic [31:0]   elapsed;
  logic          expire;
  logic [4:0]    kb;

  assign waddr      = cnt[AW-1:0];
  assign sel_idx    = AW'(req.slot_sel);
  assign at_end     = (cnt == CW'(NUM_SLOTS));
  assign sel_ok     = (32'(req.slot_sel) < 32'(NUM_SLOTS));
  assign cur_active = active[waddr];
  assign slot_hit   = at_end || !cur_active;
  // wrapping elapsed time; zero duration never expires
  assign elapsed    = req.now_ms - slot_rd.start;
  assign expire     = (slot_rd.duration != 32'd0) && (elapsed >= slot_rd.duration);
  assign kb         = kind_bit(slot_rd.kind);

  // slot memory, read address runs one step ahead of the counter
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_INJ_WR && !at_end) begin
      slot_mem[waddr] <= '{kind: req.fault_kind, start: req.now_ms,
                           duration: req.duration_in, sag: req.sag_level_in};
    end
    slot_rd <= slot_mem[cnt_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      derived_bits <= '0;
      derived_sag  <= '0;
      done         <= 1'b0;
    end else begin
      done <= (ctrl.act == ACT_EMIT);
      unique case (ctrl.act)
        ACT_INJ_WR: begin
          if (!at_end) active[waddr] <= 1'b1;
        end
        ACT_CLR_ONE: begin
          if (sel_ok) active[sel_idx] <= 1'b0;
        end
        ACT_CLR_ALL: begin
          active       <= '0;
          derived_bits <= '0;
          derived_sag  <= '0;
        end
        ACT_TICK_ACC: begin
          if (cur_active && expire) active[waddr] <= 1'b0;
        end
        ACT_TICK_END: begin
          derived_bits <= bits_acc;
          derived_sag  <= sag_acc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      req      <= cmd;
      idx      <= '0;
      ok       <= 1'b0;
      flags    <= '0;
      bits_acc <= '0;
      sag_acc  <= SAG_DEFAULT_MV;
    end else begin
      unique case (ctrl.act)
        ACT_INJ_WR: begin
          if (!at_end) begin
            idx <= 3'(cnt);
            ok  <= 1'b1;
          end
        end
        ACT_CLR_ALL: flags <= '0;
        ACT_FLAG_ACC: begin
          if (cur_active) flags <= flags | kb[3:0];
        end
        ACT_TICK_ACC: begin
          if (cur_active && !expire) begin
            bits_acc <= bits_acc | kb;
            flags    <= flags | kb[3:0];
            if (slot_rd.kind == KIND_SAG) sag_acc <= slot_rd.sag;
          end
        end
        ACT_EMIT: begin
          result <= '{slot_index: idx, inject_ok: ok,
                      gps_fault: derived_bits[0], imu_stuck: derived_bits[1],
                      battery_sag: derived_bits[2], sag_level_out: derived_sag,
                      link_down: derived_bits[3], packet_corrupt: derived_bits[4],
                      fault_flags: flags};
        end
        default: ;
      endcase
    end
  end

  `TFST_ASSERT_NEXT(a_one_strobe, clk, rst, done, !done, "result strobe held for two cycles")
  `TFST_ASSERT_NOW(a_fail_index, clk, rst, done && !result.inject_ok, result.slot_index == 3'd0, "slot index nonzero without a successful inject")
  `TFST_ASSERT_NEXT(a_clear_all, clk, rst, ctrl.act == ACT_CLR_ALL, (active == '0) && (derived_bits == '0) && (derived_sag == '0), "clear all left state behind")

endmodule

`default_nettype wire

### hw/rtl/timed_fault_slot_table_unit.sv
// Top level of the timed fault slot table: sequencer plus datapath.
// Depends on tfst_pkg, tfst_sequencer and tfst_datapath.
`default_nettype none

// Timed fault slot table. A command word is taken when start is high and busy
// is low; exactly one result word follows, shown on result for one cycle with
// done high. The receiver cannot stall: capture result whenever done is high.
// The microcode walks the slot memory one slot per cycle through its single
// registered read port: inject searches for a free slot, writes it and then
// walks all slots to gather the flags; tick and clear one walk all slots;
// clear all goes straight to the result. busy drops in the cycle done is
// high, so the next word may be taken then. No clearing pass is needed after
// reset.
module timed_fault_slot_table_unit
  import tfst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  cmd,
  output      logic busy,
  output      logic done,
  output      out_t result
);

  localparam int CW = $clog2(NUM_SLOTS + 1);

  ctrl_t         ctrl;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          slot_hit;

  tfst_sequencer #(
    .NUM_SLOTS(NUM_SLOTS),
    .CW(CW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(cmd.op),
    .slot_hit(slot_hit),
    .ctrl(ctrl),
    .cnt(cnt),
    .cnt_next(cnt_next),
    .busy(busy)
  );

  tfst_datapath #(
    .NUM_SLOTS(NUM_SLOTS),
    .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .ctrl(ctrl),
    .cnt(cnt),
    .cnt_next(cnt_next),
    .slot_hit(slot_hit),
    .done(done),
    .result(result)
  );

endmodule

`default_nettype wire
